// File: design/qbf_pkg.sv
// ----------------------------------------------------------------------------
// qbf_pkg: shared widths, constants and types
// Fixed-point widths of the quartic bond datapath, derived from the field
// widths and the fraction length; request side-band structs.
// ----------------------------------------------------------------------------
package qbf_pkg;

    localparam int INDEX_BITS      = 16;
    localparam int FRACTION_BITS   = 20;

    localparam int IDX_PORT_W      = 16;
    localparam int POS_W           = 32;
    localparam int REST_W          = 31;
    localparam int K_W             = 32;
    localparam int K_FRAC          = 16;
    localparam int OUT_W           = 48;
    localparam int PULL_GAIN_SHIFT = 2;   // factor 4 of the derivative

    localparam int DELTA_W  = POS_W + 1;
    localparam int MAG_W    = POS_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int R_W      = MAG_W + 1;
    localparam int R2_W     = 2 * R_W;
    localparam int SQ_REM_W = R_W + 4;

    localparam int D_W      = R_W;
    localparam int DD_W     = 2 * D_W;
    localparam int D2_W     = DD_W - FRACTION_BITS;
    localparam int D2_LO    = (D2_W + 1) / 2;
    localparam int D2_HI    = D2_W - D2_LO;
    localparam int D3_W     = D2_W + D_W - FRACTION_BITS;
    localparam int D3_LO    = (D3_W + 1) / 2;
    localparam int D3_HI    = D3_W - D3_LO;
    localparam int D4_W     = 2 * D2_W - FRACTION_BITS;
    localparam int D4_P     = (D4_W + 2) / 3;
    localparam int D4_TOP   = D4_W - 2 * D4_P;
    localparam int EK_W     = D4_W + K_W;
    localparam int GK_W     = D3_W + K_W;
    localparam int G_W      = GK_W - K_FRAC + PULL_GAIN_SHIFT;
    localparam int G_P      = (G_W + 2) / 3;
    localparam int G_TOP    = G_W - 2 * G_P;
    localparam int NUM_W    = G_W + MAG_W;
    localparam int Q_W      = OUT_W;

    localparam logic [OUT_W-1:0] ENERGY_MAX   = {OUT_W{1'b1}};
    localparam logic [OUT_W-1:0] PULL_POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] PULL_NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic [INDEX_BITS-1:0]   idx_a;
        logic [INDEX_BITS-1:0]   idx_b;
        logic [2:0]              neg;
        logic [2:0][MAG_W-1:0]   mag;
        logic [REST_W-1:0]       rest;
        logic [K_W-1:0]          k;
    } bond_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]   idx_a;
        logic [INDEX_BITS-1:0]   idx_b;
        logic [2:0]              sn;
        logic                    zero;
        logic [R_W-1:0]          r;
        logic [OUT_W-1:0]        energy;
        logic                    e_sat;
    } pull_side_t;

    typedef struct packed {
        pull_side_t              side;
        logic [2:0]              ovf;
        logic [2:0][Q_W-1:0]     q;
    } div_out_t;

endpackage

// File: design/quartic_bond_force.sv
// ----------------------------------------------------------------------------
// quartic_bond_force: quartic bond energy and pull vector
// Throughput: one request per cycle while the output is not stalled, set by
//   the fully pipelined square root (33 stages) and divider (49 stages); no
//   multicycle unit is shared.
// Reset: synchronous active-low aresetn clears every valid bit; payload
//   registers are not reset. No state survives between requests.
// ----------------------------------------------------------------------------
module quartic_bond_force (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [qbf_pkg::IDX_PORT_W-1:0]       s_first_index,
    input  logic [qbf_pkg::IDX_PORT_W-1:0]       s_second_index,
    input  logic signed [qbf_pkg::POS_W-1:0]     s_first_x,
    input  logic signed [qbf_pkg::POS_W-1:0]     s_first_y,
    input  logic signed [qbf_pkg::POS_W-1:0]     s_first_z,
    input  logic signed [qbf_pkg::POS_W-1:0]     s_second_x,
    input  logic signed [qbf_pkg::POS_W-1:0]     s_second_y,
    input  logic signed [qbf_pkg::POS_W-1:0]     s_second_z,
    input  logic [qbf_pkg::REST_W-1:0]           s_rest_length,
    input  logic [qbf_pkg::K_W-1:0]              s_stiffness,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [qbf_pkg::IDX_PORT_W-1:0]       m_out_first_index,
    output logic [qbf_pkg::IDX_PORT_W-1:0]       m_out_second_index,
    output logic signed [qbf_pkg::OUT_W-1:0]     m_pull_x,
    output logic signed [qbf_pkg::OUT_W-1:0]     m_pull_y,
    output logic signed [qbf_pkg::OUT_W-1:0]     m_pull_z,
    output logic [qbf_pkg::OUT_W-1:0]            m_energy_term,
    output logic                                 m_saturated
);
    import qbf_pkg::*;

    // Pipeline control: every stage shares one enable. The pipe only stops
    // when its last stage holds a request and the output register is full
    // and not being drained, so bubbles still let new requests in.
    logic en;
    logic ld;
    logic tail_v;

    // Stage 1: delta = first - second, split into sign and magnitude
    logic [2:0][POS_W-1:0]   pos_a;
    logic [2:0][POS_W-1:0]   pos_b;
    bond_t                   b1_next;
    bond_t                   b1_reg;
    logic                    v1_reg;
    // Stage 2: squares of the magnitudes
    logic [2:0][SQ_W-1:0]    sq_reg;
    bond_t                   b2_reg;
    logic                    v2_reg;
    // Stage 3: r^2
    logic [R2_W-1:0]         r2_reg;
    bond_t                   b3_reg;
    logic                    v3_reg;

    // Downstream of the square root
    logic                    sqrt_v;
    bond_t                   sqrt_bond;
    logic [R_W-1:0]          sqrt_root;
    logic                    poly_v;
    pull_side_t              poly_side;
    logic [2:0][NUM_W-1:0]   poly_num;
    div_out_t                tail;

    // Output register
    logic                    m_valid_reg;
    logic [INDEX_BITS-1:0]   idx_a_reg;
    logic [INDEX_BITS-1:0]   idx_b_reg;
    logic [2:0][OUT_W-1:0]   pull_reg;
    logic [OUT_W-1:0]        energy_reg;
    logic                    sat_reg;
    logic [2:0][OUT_W-1:0]   pull_next;
    logic                    sat_next;

    assign ld      = !m_valid_reg || m_ready;
    assign en      = !tail_v || ld;
    assign s_ready = en;

    assign pos_a = {s_first_z, s_first_y, s_first_x};
    assign pos_b = {s_second_z, s_second_y, s_second_x};

    always_comb begin
        logic [DELTA_W-1:0] dlt;
        logic [DELTA_W-1:0] mag_w;
        b1_next.idx_a = s_first_index[INDEX_BITS-1:0];
        b1_next.idx_b = s_second_index[INDEX_BITS-1:0];
        b1_next.rest  = s_rest_length;
        b1_next.k     = s_stiffness;
        for (int c = 0; c < 3; c++) begin
            dlt   = {pos_a[c][POS_W-1], pos_a[c]} - {pos_b[c][POS_W-1], pos_b[c]};
            mag_w = dlt[DELTA_W-1] ? (~dlt + 1'b1) : dlt;
            b1_next.neg[c] = dlt[DELTA_W-1];
            b1_next.mag[c] = mag_w[MAG_W-1:0];   // |delta| < 2^32
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (en) begin
            b1_reg <= b1_next;
            b2_reg <= b1_reg;
            b3_reg <= b2_reg;
            for (int c = 0; c < 3; c++) begin
                sq_reg[c] <= b1_reg.mag[c] * b1_reg.mag[c];
            end
            r2_reg <= R2_W'(sq_reg[0]) + R2_W'(sq_reg[1]) + R2_W'(sq_reg[2]);
        end
    end

    // r = floor(sqrt(r^2)), one bit per stage
    qbf_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_bond   (b3_reg),
        .in_r2     (r2_reg),
        .out_valid (sqrt_v),
        .out_bond  (sqrt_bond),
        .out_root  (sqrt_root)
    );

    // dr, its powers, the energy term and gain*|delta| numerators
    qbf_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sqrt_v),
        .in_bond   (sqrt_bond),
        .in_root   (sqrt_root),
        .out_valid (poly_v),
        .out_side  (poly_side),
        .out_num   (poly_num)
    );

    // numerator / r for the three axes
    qbf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (poly_v),
        .in_side   (poly_side),
        .in_num    (poly_num),
        .out_valid (tail_v),
        .out_quot  (tail)
    );

    // Clip each quotient to the signed 48-bit range and apply the sign.
    // Zero distance forces the whole pull to zero; the pull then never sets the flag.
    always_comb begin
        logic [OUT_W-1:0] lim;
        logic [OUT_W-1:0] mag;
        logic             clip;
        sat_next = tail.side.e_sat;
        for (int c = 0; c < 3; c++) begin
            lim  = tail.side.sn[c] ? PULL_NEG_MAG : PULL_POS_LIM;
            clip = tail.ovf[c] || (tail.q[c] > lim);
            mag  = clip ? lim : tail.q[c];
            if (tail.side.zero) begin
                pull_next[c] = '0;
            end else begin
                pull_next[c] = tail.side.sn[c] ? (~mag + 1'b1) : mag;
                sat_next     = sat_next | clip;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ld) begin
            m_valid_reg <= tail_v;
        end
        if (ld && tail_v) begin
            idx_a_reg  <= tail.side.idx_a;
            idx_b_reg  <= tail.side.idx_b;
            pull_reg   <= pull_next;
            energy_reg <= tail.side.energy;
            sat_reg    <= sat_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_out_first_index  = IDX_PORT_W'(idx_a_reg);
    assign m_out_second_index = IDX_PORT_W'(idx_b_reg);
    assign m_pull_x           = pull_reg[0];
    assign m_pull_y           = pull_reg[1];
    assign m_pull_z           = pull_reg[2];
    assign m_energy_term      = energy_reg;
    assign m_saturated        = sat_reg;

    // Flag needs a clipped value: with no field at a limit it must be clear.
    a_sat_needs_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && energy_reg != ENERGY_MAX
         && pull_reg[0] != PULL_POS_LIM && pull_reg[0] != PULL_NEG_MAG
         && pull_reg[1] != PULL_POS_LIM && pull_reg[1] != PULL_NEG_MAG
         && pull_reg[2] != PULL_POS_LIM && pull_reg[2] != PULL_NEG_MAG)
        |-> !sat_reg)
        else $error("saturated set without a clipped field");

    // A request blocked at the pipe tail stays there for the next cycle.
    a_tail_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && tail_v) |=> tail_v)
        else $error("stalled tail request lost");

endmodule

// File: design/qbf_isqrt.sv
// ----------------------------------------------------------------------------
// qbf_isqrt: pipelined integer square root
// One result bit per stage, restoring digit recurrence on the radicand.
// ----------------------------------------------------------------------------
module qbf_isqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  qbf_pkg::bond_t            in_bond,
    input  logic [qbf_pkg::R2_W-1:0]  in_r2,
    output logic                      out_valid,
    output qbf_pkg::bond_t            out_bond,
    output logic [qbf_pkg::R_W-1:0]   out_root
);
    import qbf_pkg::*;

    typedef struct packed {
        bond_t                 bond;
        logic [R2_W-1:0]       rad;
        logic [SQ_REM_W-1:0]   rem;
        logic [R_W-1:0]        root;
    } sq_stage_t;

    sq_stage_t stg_in [R_W];
    sq_stage_t st_reg [R_W];
    logic      v_in   [R_W];
    logic      v_reg  [R_W];

    assign stg_in[0] = '{bond: in_bond, rad: in_r2, rem: '0, root: '0};
    assign v_in[0]   = in_valid;

    for (genvar i = 0; i < R_W; i++) begin : g_stage
        sq_stage_t           nxt;
        logic [SQ_REM_W-1:0] cur;
        logic [SQ_REM_W-1:0] trial;

        if (i > 0) begin : g_link
            assign stg_in[i] = st_reg[i-1];
            assign v_in[i]   = v_reg[i-1];
        end

        always_comb begin
            nxt     = stg_in[i];
            cur     = {stg_in[i].rem[SQ_REM_W-3:0], stg_in[i].rad[R2_W-1 -: 2]};
            trial   = SQ_REM_W'({stg_in[i].root, 2'b01});
            nxt.rad = stg_in[i].rad << 2;
            if (cur >= trial) begin
                nxt.rem  = cur - trial;
                nxt.root = {stg_in[i].root[R_W-2:0], 1'b1};
            end else begin
                nxt.rem  = cur;
                nxt.root = {stg_in[i].root[R_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_in[i];
            end
            if (en) begin
                st_reg[i] <= nxt;
            end
        end
    end

    assign out_valid = v_reg[R_W-1];
    assign out_bond  = st_reg[R_W-1].bond;
    assign out_root  = st_reg[R_W-1].root;

    // remainder of a finished root never exceeds 2*root
    a_root_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[R_W-1] |->
            st_reg[R_W-1].rem <= SQ_REM_W'({st_reg[R_W-1].root, 1'b0}))
        else $error("isqrt remainder out of range");

endmodule

// File: design/qbf_poly.sv
// ----------------------------------------------------------------------------
// qbf_poly: stretch, powers, energy and pull numerators
// Eight stages: |r-rest|, d^2, split products for d^3 and d^4, stiffness
// products, energy clip and gain, then gain times each delta magnitude.
// ----------------------------------------------------------------------------
module qbf_poly (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  qbf_pkg::bond_t                       in_bond,
    input  logic [qbf_pkg::R_W-1:0]              in_root,
    output logic                                 out_valid,
    output qbf_pkg::pull_side_t                  out_side,
    output logic [2:0][qbf_pkg::NUM_W-1:0]       out_num
);
    import qbf_pkg::*;

    localparam int NSTG = 8;

    typedef struct packed {
        logic [INDEX_BITS-1:0] idx_a;
        logic [INDEX_BITS-1:0] idx_b;
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
        logic [K_W-1:0]        k;
        logic [R_W-1:0]        r;
        logic [D_W-1:0]        d;
        logic                  drn;
        logic [OUT_W-1:0]      energy;
        logic                  e_sat;
    } poly_side_t;

    poly_side_t                    side_reg [NSTG];
    logic [NSTG-1:0]               v_reg;
    logic [DD_W-1:0]               dd_reg;
    logic [D2_LO+D_W-1:0]          pa_reg;
    logic [D2_HI+D_W-1:0]          pb_reg;
    logic [D2_LO+D2_W-1:0]         pc_reg;
    logic [D2_HI+D2_W-1:0]         pd_reg;
    logic [D3_W-1:0]               d3_reg;
    logic [D4_W-1:0]               d4_reg;
    logic [D4_P+K_W-1:0]           ea_reg;
    logic [D4_P+K_W-1:0]           eb_reg;
    logic [D4_TOP+K_W-1:0]         ec_reg;
    logic [D3_LO+K_W-1:0]          ga_reg;
    logic [D3_HI+K_W-1:0]          gb_reg;
    logic [G_W-1:0]                g_reg;
    logic [2:0][G_P+MAG_W-1:0]     ma_reg;
    logic [2:0][G_P+MAG_W-1:0]     mb_reg;
    logic [2:0][G_TOP+MAG_W-1:0]   mc_reg;
    logic [2:0][NUM_W-1:0]         num_reg;

    poly_side_t                    s1_next;
    poly_side_t                    s6_next;
    logic [R_W:0]                  rdiff;
    logic [R_W:0]                  rabs;
    logic [D2_W-1:0]               d2;
    logic [D2_W+D_W-1:0]           d3_full;
    logic [2*D2_W-1:0]             d4_full;
    logic [EK_W-1:0]               ek;
    logic [GK_W-1:0]               gk;
    logic [G_W-1:0]                g_next;
    logic [2:0][NUM_W-1:0]         num_next;

    always_comb begin
        rdiff          = (R_W+1)'(in_root) - (R_W+1)'(in_bond.rest);
        rabs           = rdiff[R_W] ? (~rdiff + 1'b1) : rdiff;
        s1_next.idx_a  = in_bond.idx_a;
        s1_next.idx_b  = in_bond.idx_b;
        s1_next.neg    = in_bond.neg;
        s1_next.mag    = in_bond.mag;
        s1_next.k      = in_bond.k;
        s1_next.r      = in_root;
        s1_next.d      = rabs[D_W-1:0];
        s1_next.drn    = rdiff[R_W];
        s1_next.energy = '0;
        s1_next.e_sat  = 1'b0;
    end

    assign d2      = dd_reg[DD_W-1:FRACTION_BITS];
    assign d3_full = (D2_W+D_W)'(pa_reg) + ((D2_W+D_W)'(pb_reg) << D2_LO);
    assign d4_full = (2*D2_W)'(pc_reg) + ((2*D2_W)'(pd_reg) << D2_LO);

    always_comb begin
        ek = EK_W'(ea_reg) + (EK_W'(eb_reg) << D4_P) + (EK_W'(ec_reg) << (2 * D4_P));
        gk = GK_W'(ga_reg) + (GK_W'(gb_reg) << D3_LO);
        g_next  = G_W'(gk[GK_W-1:K_FRAC]) << PULL_GAIN_SHIFT;
        s6_next = side_reg[4];
        if (|ek[EK_W-1:K_FRAC+OUT_W]) begin
            s6_next.energy = ENERGY_MAX;
            s6_next.e_sat  = 1'b1;
        end else begin
            s6_next.energy = ek[K_FRAC+OUT_W-1:K_FRAC];
            s6_next.e_sat  = 1'b0;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            num_next[c] = NUM_W'(ma_reg[c]) + (NUM_W'(mb_reg[c]) << G_P)
                        + (NUM_W'(mc_reg[c]) << (2 * G_P));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NSTG-2:0], in_valid};
        end
        if (en) begin
            side_reg[0] <= s1_next;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
            side_reg[3] <= side_reg[2];
            side_reg[4] <= side_reg[3];
            side_reg[5] <= s6_next;
            side_reg[6] <= side_reg[5];
            side_reg[7] <= side_reg[6];
            // stage 2
            dd_reg <= side_reg[0].d * side_reg[0].d;
            // stage 3
            pa_reg <= d2[D2_LO-1:0] * side_reg[1].d;
            pb_reg <= d2[D2_W-1:D2_LO] * side_reg[1].d;
            pc_reg <= d2[D2_LO-1:0] * d2;
            pd_reg <= d2[D2_W-1:D2_LO] * d2;
            // stage 4
            d3_reg <= d3_full[D2_W+D_W-1:FRACTION_BITS];
            d4_reg <= d4_full[2*D2_W-1:FRACTION_BITS];
            // stage 5
            ea_reg <= d4_reg[D4_P-1:0] * side_reg[3].k;
            eb_reg <= d4_reg[2*D4_P-1:D4_P] * side_reg[3].k;
            ec_reg <= d4_reg[D4_W-1:2*D4_P] * side_reg[3].k;
            ga_reg <= d3_reg[D3_LO-1:0] * side_reg[3].k;
            gb_reg <= d3_reg[D3_W-1:D3_LO] * side_reg[3].k;
            // stage 6
            g_reg  <= g_next;
            // stage 7
            for (int c = 0; c < 3; c++) begin
                ma_reg[c] <= g_reg[G_P-1:0] * side_reg[5].mag[c];
                mb_reg[c] <= g_reg[2*G_P-1:G_P] * side_reg[5].mag[c];
                mc_reg[c] <= g_reg[G_W-1:2*G_P] * side_reg[5].mag[c];
            end
            // stage 8
            num_reg <= num_next;
        end
    end

    assign out_valid       = v_reg[NSTG-1];
    assign out_side.idx_a  = side_reg[NSTG-1].idx_a;
    assign out_side.idx_b  = side_reg[NSTG-1].idx_b;
    assign out_side.sn     = side_reg[NSTG-1].neg ^ {3{side_reg[NSTG-1].drn}};
    assign out_side.zero   = (side_reg[NSTG-1].r == '0);
    assign out_side.r      = side_reg[NSTG-1].r;
    assign out_side.energy = side_reg[NSTG-1].energy;
    assign out_side.e_sat  = side_reg[NSTG-1].e_sat;
    assign out_num         = num_reg;

endmodule

// File: design/qbf_div.sv
// ----------------------------------------------------------------------------
// qbf_div: pipelined divide of three pull numerators by the distance
// Overflow check against r*2^48, then one quotient bit per stage per lane.
// ----------------------------------------------------------------------------
module qbf_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  qbf_pkg::pull_side_t               in_side,
    input  logic [2:0][qbf_pkg::NUM_W-1:0]    in_num,
    output logic                              out_valid,
    output qbf_pkg::div_out_t                 out_quot
);
    import qbf_pkg::*;

    localparam int HI_W = NUM_W - Q_W;

    typedef struct packed {
        pull_side_t            side;
        logic [2:0]            ovf;
        logic [2:0][R_W-1:0]   rem;
        logic [2:0][Q_W-1:0]   low;
    } dv_stage_t;

    dv_stage_t st_reg [Q_W+1];
    logic      v_reg  [Q_W+1];
    dv_stage_t st0_next;

    always_comb begin
        st0_next.side = in_side;
        for (int c = 0; c < 3; c++) begin
            st0_next.ovf[c] = !in_side.zero &&
                              (in_num[c][NUM_W-1:Q_W] >= HI_W'(in_side.r));
            st0_next.rem[c] = in_num[c][Q_W+R_W-1:Q_W];
            st0_next.low[c] = in_num[c][Q_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
        if (en) begin
            st_reg[0] <= st0_next;
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_step
        dv_stage_t nxt;

        always_comb begin
            logic [R_W:0] cur;
            logic [R_W:0] dif;
            nxt = st_reg[j];
            for (int c = 0; c < 3; c++) begin
                cur = {st_reg[j].rem[c], st_reg[j].low[c][Q_W-1]};
                dif = cur - (R_W+1)'(st_reg[j].side.r);
                if (cur >= (R_W+1)'(st_reg[j].side.r)) begin
                    nxt.rem[c] = dif[R_W-1:0];
                    nxt.low[c] = {st_reg[j].low[c][Q_W-2:0], 1'b1};
                end else begin
                    nxt.rem[c] = cur[R_W-1:0];
                    nxt.low[c] = {st_reg[j].low[c][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j+1] <= 1'b0;
            end else if (en) begin
                v_reg[j+1] <= v_reg[j];
            end
            if (en) begin
                st_reg[j+1] <= nxt;
            end
        end
    end

    assign out_valid     = v_reg[Q_W];
    assign out_quot.side = st_reg[Q_W].side;
    assign out_quot.ovf  = st_reg[Q_W].ovf;
    assign out_quot.q    = st_reg[Q_W].low;

    // a finished lane that did not overflow leaves a remainder below r (checked on lane 0)
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[Q_W] && !st_reg[Q_W].side.zero && !st_reg[Q_W].ovf[0]) |->
            st_reg[Q_W].rem[0] < st_reg[Q_W].side.r)
        else $error("divider remainder not below divisor");

endmodule
